// File: sv/utf8sd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared payload types, the internal job descriptor and the fixed constants
// of the decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP2  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;

  // Sequence lengths held in the pending-sequence state.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Most results that one input byte can cause.
  localparam logic [2:0] MAX_RESULTS = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } utf8sd_in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            run_last;
  } utf8sd_out_t;

  // Work left from one byte: a run of replacements, then an optional
  // decoded scalar value.
  typedef struct packed {
    logic [2:0]      repl_cnt;
    logic            tail_vld;
    logic [CP_W-1:0] tail_cp;
  } utf8sd_job_t;

endpackage : utf8sd_pkg
`default_nettype wire

// File: sv/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into Unicode code points, replacing malformed input
// with U+FFFD.
// ----------------------------------------------------------------------------
// The decoder takes one UTF-8 byte per input transaction and gives zero to
// four result transactions for it, each a 21-bit code point with a replaced
// flag and a run_last flag on the final result of that byte. A byte that
// causes at most one result is taken every cycle when the output side keeps
// up; a byte that causes several results holds the emitter until the last
// moves out, since the emitter hands one result a cycle to the single output
// register when the output side keeps up. Bytes that only extend a pending
// sequence give no result. A result is held in the job register, then in
// the output register. Malformed input follows the usual replacement rules: an
// invalid lead byte gives one U+FFFD, a sequence cut short by a
// non-continuation byte gives one U+FFFD per byte already taken (the new byte
// is then decoded as a lead), and a completed sequence that is overlong, a
// surrogate or above U+10FFFF gives one U+FFFD per byte. Setting final_byte
// flushes a pending sequence in the same way. The output register parts the
// two sides, so a new byte is taken while a finished result is still waiting.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire utf8sd_in_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output utf8sd_out_t      out_data
);

  // A transaction on the input channel updates the sequence state and loads
  // a fresh job into the emitter in the same edge.
  logic        in_fire;
  utf8sd_job_t job;

  assign in_fire = in_valid && in_ready;

  // Decode stage: pending-sequence state plus the per-byte classification.
  utf8sd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .job     (job)
  );

  // Emitter: walks the job one result a cycle into the output register while
  // unstalled, and frees itself for the next byte as the last result leaves.
  utf8sd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .job_in    (job),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : utf8_stream_decoder
`default_nettype wire

// File: sv/utf8sd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 byte decode stage
// Holds the pending-sequence state and turns each accepted byte into a job:
// a count of replacement results and an optional decoded code point.
// ----------------------------------------------------------------------------
module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire utf8sd_in_t  in_item,
  output utf8sd_job_t      job
);

  logic [2:0]      exp_len_r, exp_len_nxt;
  logic [1:0]      taken_r, taken_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;

  logic [7:0]      b;
  logic            fin;
  logic            pend;
  logic            is_cont;
  logic [2:0]      taken_inc;
  logic [CP_W-1:0] partial_shift;
  logic            cp_ok;
  logic [2:0]      lead_len;
  logic [CP_W-1:0] lead_bits;
  logic            is_ascii;

  assign b             = in_item.data_byte;
  assign fin           = in_item.final_byte;
  assign pend          = (exp_len_r != LEN_NONE);
  assign is_cont       = (b[7:6] == 2'b10);
  assign taken_inc     = {1'b0, taken_r} + 3'd1;
  assign partial_shift = {partial_r[CP_W-7:0], b[5:0]};

  // Range check of a completed sequence: not overlong, not a surrogate,
  // not beyond the last scalar value.
  always_comb begin
    cp_ok = 1'b1;
    if ((exp_len_r == LEN_2) && (partial_shift < MIN_CP2)) cp_ok = 1'b0;
    if ((exp_len_r == LEN_3) && (partial_shift < MIN_CP3)) cp_ok = 1'b0;
    if ((exp_len_r == LEN_4) && (partial_shift < MIN_CP4)) cp_ok = 1'b0;
    if (partial_shift > MAX_CP) cp_ok = 1'b0;
    if ((partial_shift >= SURR_LO) && (partial_shift <= SURR_HI)) cp_ok = 1'b0;
  end

  always_comb begin
    is_ascii  = 1'b0;
    lead_len  = LEN_NONE;
    lead_bits = '0;
    unique case (b) inside
      8'b0???????: begin
        is_ascii = 1'b1;
      end
      8'b110?????: begin
        lead_len  = LEN_2;
        lead_bits = {16'd0, b[4:0]};
      end
      8'b1110????: begin
        lead_len  = LEN_3;
        lead_bits = {17'd0, b[3:0]};
      end
      8'b11110???: begin
        lead_len  = LEN_4;
        lead_bits = {18'd0, b[2:0]};
      end
      default: begin
        lead_len = LEN_NONE;
      end
    endcase
  end

  always_comb begin
    job         = '0;
    exp_len_nxt = exp_len_r;
    taken_nxt   = taken_r;
    partial_nxt = partial_r;
    if (pend && is_cont) begin
      if (taken_inc >= exp_len_r) begin
        if (cp_ok) begin
          job.tail_vld = 1'b1;
          job.tail_cp  = partial_shift;
        end else begin
          job.repl_cnt = exp_len_r;
        end
        exp_len_nxt = LEN_NONE;
        taken_nxt   = '0;
        partial_nxt = '0;
      end else if (fin) begin
        job.repl_cnt = taken_inc;
        exp_len_nxt  = LEN_NONE;
        taken_nxt    = '0;
        partial_nxt  = '0;
      end else begin
        taken_nxt   = taken_inc[1:0];
        partial_nxt = partial_shift;
      end
    end else begin
      // A non-continuation byte abandons whatever is pending.
      if (pend) begin
        job.repl_cnt = {1'b0, taken_r};
      end
      exp_len_nxt = LEN_NONE;
      taken_nxt   = '0;
      partial_nxt = '0;
      if (is_ascii) begin
        job.tail_vld = 1'b1;
        job.tail_cp  = {13'd0, b};
      end else if ((lead_len != LEN_NONE) && !fin) begin
        exp_len_nxt = lead_len;
        taken_nxt   = 2'd1;
        partial_nxt = lead_bits;
      end else begin
        job.repl_cnt = job.repl_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= LEN_NONE;
      taken_r   <= '0;
      partial_r <= '0;
    end else if (in_fire) begin
      exp_len_r <= exp_len_nxt;
      taken_r   <= taken_nxt;
      partial_r <= partial_nxt;
    end
  end

  a_idle_state_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r == LEN_NONE) |-> (taken_r == 2'd0))
    else $error("taken count nonzero with no pending sequence");

  a_taken_below_len : assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r != LEN_NONE) |-> (({1'b0, taken_r} < exp_len_r) && (taken_r != 2'd0)))
    else $error("taken count out of range for pending sequence");

endmodule : utf8sd_decode
`default_nettype wire

// File: sv/utf8sd_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 result emitter
// Holds the job of the last byte and feeds its results into the output
// register, one a cycle whenever that register is free or being drained.
// ----------------------------------------------------------------------------
module utf8sd_emit
  import utf8sd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_fire,
  input  wire utf8sd_job_t  job_in,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output utf8sd_out_t       out_data
);

  utf8sd_job_t job_r;
  utf8sd_out_t out_r;
  logic        out_valid_r;

  logic        job_busy;
  logic        job_last;
  logic        move;
  utf8sd_out_t item;

  assign job_busy = (job_r.repl_cnt != 3'd0) || job_r.tail_vld;
  assign job_last = ((job_r.repl_cnt == 3'd1) && !job_r.tail_vld) ||
                    ((job_r.repl_cnt == 3'd0) && job_r.tail_vld);
  assign move     = job_busy && (!out_valid_r || out_ready);
  assign in_ready = !job_busy || (move && job_last);

  always_comb begin
    if (job_r.repl_cnt != 3'd0) begin
      item.code_point = REPL_CP;
      item.replaced   = 1'b1;
      item.run_last   = (job_r.repl_cnt == 3'd1) && !job_r.tail_vld;
    end else begin
      item.code_point = job_r.tail_cp;
      item.replaced   = 1'b0;
      item.run_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
    end else if (in_fire) begin
      job_r <= job_in;
    end else if (move) begin
      if (job_r.repl_cnt != 3'd0) begin
        job_r.repl_cnt <= job_r.repl_cnt - 3'd1;
      end else begin
        job_r.tail_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_job_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    job_r.repl_cnt <= MAX_RESULTS)
    else $error("job holds more replacements than one byte can cause");

  a_decoded_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.replaced) |-> out_r.run_last)
    else $error("decoded code point not marked as last of its run");

  a_decoded_scalar : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.replaced) |->
      ((out_r.code_point <= MAX_CP) &&
       ((out_r.code_point < SURR_LO) || (out_r.code_point > SURR_HI))))
    else $error("decoded result is not a Unicode scalar value");

  a_no_job_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && job_busy) |-> (move && job_last))
    else $error("new byte taken while job still had results pending");

endmodule : utf8sd_emit
`default_nettype wire
